FILE: rtl/saa_pkg.sv
// Package: shared constants, types and codes of the shelf atlas allocator.
`default_nettype none

package saa_pkg;

   localparam int MAX_SHELVES = 64;
   localparam int SHELF_IDX_W = $clog2(MAX_SHELVES);
   localparam int COUNT_W     = $clog2(MAX_SHELVES + 1);
   localparam int DIM_W       = 13;   // map and request dimensions
   localparam int POS_W       = 12;   // positions and shelf tops
   localparam int NEED_W      = DIM_W + 1;
   localparam int CSR_IDX_W   = 2;

   localparam logic [DIM_W-1:0]  MAP_RESET  = DIM_W'(512);
   localparam logic [NEED_W-1:0] BORDER_PAD = NEED_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SHELVES);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_PLACED   = 2'd0,
      STATUS_NO_FIT   = 2'd1,
      STATUS_TBL_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0] top;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] used;
   } shelf_entry_type;

   typedef struct packed {
      logic                   en;
      logic [SHELF_IDX_W-1:0] addr;
      shelf_entry_type        entry;
   } shelf_wr_type;

endpackage

`default_nettype wire

FILE: rtl/saa_shelf_ram.sv
// Shelf table memory: one write port, one registered read port.
`default_nettype none

module saa_shelf_ram
   import saa_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [SHELF_IDX_W-1:0] rd_addr,
   output shelf_entry_type             rd_data,
   input  wire shelf_wr_type           wr
);

   shelf_entry_type mem [MAX_SHELVES];
   shelf_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/shelf_atlas_allocator.sv
// Top level of the shelf atlas allocator: control sequencer and result port.
//
// Shelf atlas allocator. A request (start high while busy is low) gives a
// rectangle; unless it equals the whole map it is padded by one pixel on
// every side. The first request creates one shelf covering the map. The
// shelf table sits in a synchronous memory that is scanned one shelf per
// cycle, and busy stays high until the result strobe shows. The result
// is held on rsp_* for exactly one cycle with rsp_valid high and cannot be
// stalled by the receiver; a new request may be issued in the same cycle
// the result shows. Map size registers are written through the csr_*
// channel, which is always ready; write them only while the block is idle.
// No clearing pass is needed after reset.
`default_nettype none

module shelf_atlas_allocator
   import saa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [DIM_W-1:0]     req_rect_width,
   input  wire logic [DIM_W-1:0]     req_rect_height,
   // result channel
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [POS_W-1:0]          rsp_place_x,
   output logic [POS_W-1:0]          rsp_place_y,
   // register write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata
);

   // control state
   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;        // shelves in use
   logic [COUNT_W-1:0]     issue_ff, issue_in;    // next shelf to read
   logic                   rd_vld_ff, rd_vld_in;  // read data valid this cycle
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]       map_w_ff, map_w_in;
   logic [DIM_W-1:0]       map_h_ff, map_h_in;

   // request payload
   logic [SHELF_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [NEED_W-1:0]      need_w_ff, need_w_in;
   logic [NEED_W-1:0]      need_h_ff, need_h_in;
   logic                   border_ff, border_in;
   logic [SHELF_IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [POS_W-1:0]       best_top_ff, best_top_in;
   logic [DIM_W-1:0]       best_h_ff, best_h_in;
   logic [DIM_W-1:0]       best_used_ff, best_used_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]       rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]       rsp_y_ff, rsp_y_in;

   shelf_entry_type        rd_data;
   shelf_wr_type           wr;

   logic                   accept;
   logic                   whole_map;
   logic [NEED_W:0]        fit_w;      // shelf used + needed width
   logic                   candidate;

   saa_shelf_ram u_shelf_ram (
      .clock   (clock),
      .rd_addr (issue_ff[SHELF_IDX_W-1:0]),
      .rd_data (rd_data),
      .wr      (wr)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign whole_map = (req_rect_width == map_w_ff) && (req_rect_height == map_h_ff);

   // Scan compare: strictly smaller height wins, so ties keep the earlier shelf.
   assign fit_w     = {2'b00, rd_data.used} + {1'b0, need_w_ff};
   assign candidate = (!found_ff || (rd_data.height < best_h_ff))
                   && (need_h_ff <= {1'b0, rd_data.height})
                   && (fit_w <= {2'b00, map_w_ff});

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      map_w_in      = map_w_ff;
      map_h_in      = map_h_ff;
      rd_idx_in     = rd_idx_ff;
      need_w_in     = need_w_ff;
      need_h_in     = need_h_ff;
      border_in     = border_ff;
      best_idx_in   = best_idx_ff;
      best_top_in   = best_top_ff;
      best_h_in     = best_h_ff;
      best_used_in  = best_used_ff;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      wr            = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_w_in = csr_wdata;
            CSR_MAP_HEIGHT: map_h_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               border_in = !whole_map;
               need_w_in = {1'b0, req_rect_width} + (whole_map ? '0 : BORDER_PAD);
               need_h_in = {1'b0, req_rect_height} + (whole_map ? '0 : BORDER_PAD);
               found_in  = 1'b0;
               issue_in  = '0;
               state_in  = ST_SCAN;
               // first request ever: one shelf covering the whole map
               if (cnt_ff == '0) begin
                  wr.en           = 1'b1;
                  wr.addr         = '0;
                  wr.entry.top    = '0;
                  wr.entry.height = map_h_ff;
                  wr.entry.used   = '0;
                  cnt_in          = COUNT_W'(1);
               end
            end
         end

         ST_SCAN: begin
            if (issue_ff < cnt_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[SHELF_IDX_W-1:0];
               issue_in  = issue_ff + COUNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
            if (rd_vld_ff && candidate) begin
               found_in     = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_top_in  = rd_data.top;
               best_h_in    = rd_data.height;
               best_used_in = rd_data.used;
            end
         end

         ST_DECIDE: begin
            if (!found_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_FIT;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               state_in      = ST_IDLE;
            end else if ((best_used_ff == '0) && (need_h_ff < {1'b0, best_h_ff})) begin
               if (cnt_ff >= COUNT_MAX) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_TBL_FULL;
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  state_in      = ST_IDLE;
               end else begin
                  // split: spare height becomes a new empty shelf at the end
                  wr.en           = 1'b1;
                  wr.addr         = cnt_ff[SHELF_IDX_W-1:0];
                  wr.entry.top    = best_top_ff + need_h_ff[POS_W-1:0];
                  wr.entry.height = best_h_ff - need_h_ff[DIM_W-1:0];
                  wr.entry.used   = '0;
                  cnt_in          = cnt_ff + COUNT_W'(1);
                  best_h_in       = need_h_ff[DIM_W-1:0];
                  state_in        = ST_COMMIT;
               end
            end else begin
               state_in = ST_COMMIT;
            end
         end

         ST_COMMIT: begin
            wr.en           = 1'b1;
            wr.addr         = best_idx_ff;
            wr.entry.top    = best_top_ff;
            wr.entry.height = best_h_ff;
            wr.entry.used   = best_used_ff + need_w_ff[DIM_W-1:0];
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_PLACED;
            rsp_x_in        = best_used_ff[POS_W-1:0] + POS_W'(border_ff);
            rsp_y_in        = best_top_ff + POS_W'(border_ff);
            state_in        = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_w_ff     <= MAP_RESET;
         map_h_ff     <= MAP_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         map_w_ff     <= map_w_in;
         map_h_ff     <= map_h_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      need_w_ff     <= need_w_in;
      need_h_ff     <= need_h_in;
      border_ff     <= border_in;
      best_idx_ff   <= best_idx_in;
      best_top_ff   <= best_top_in;
      best_h_ff     <= best_h_in;
      best_used_ff  <= best_used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_place_x = rsp_x_ff;
   assign rsp_place_y = rsp_y_ff;

endmodule

`default_nettype wire

FILE: test/shelf_atlas_allocator_tb.sv
// Self-checking testbench of the shelf atlas allocator: directed and random requests.
`default_nettype none

module shelf_atlas_allocator_tb
   import saa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // no-progress cycles before the run is declared hung
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 80;

   // random phases: map size, request count and sender idle percentage
   localparam int NUM_PHASES = 7;
   localparam int PHASE_WIDTH  [NUM_PHASES] = '{64, 1, 0, 1024, 2048, 4096, 8191};
   localparam int PHASE_HEIGHT [NUM_PHASES] = '{512, 1, 0, 4096, 100, 8191, 4095};
   localparam int PHASE_ITEMS  [NUM_PHASES] = '{250, 60, 40, 300, 300, 300, 400};
   localparam int PHASE_IDLE   [NUM_PHASES] = '{0, 76, 33, 76, 0, 33, 0};

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } placement_type;

   // Mirror of the shelf table plus the placements still owed by the block.
   class shelf_tracker;
      logic [DIM_W-1:0] map_w;
      logic [DIM_W-1:0] map_h;
      logic [POS_W-1:0] top    [MAX_SHELVES];
      logic [DIM_W-1:0] height [MAX_SHELVES];
      logic [DIM_W-1:0] used   [MAX_SHELVES];
      int unsigned      count;
      placement_type    placements_due [$];
      int               errors;

      function new();
         map_w  = MAP_RESET;
         map_h  = MAP_RESET;
         count  = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [DIM_W-1:0] value);
         case (idx)
            CSR_MAP_WIDTH:  map_w = value;
            CSR_MAP_HEIGHT: map_h = value;
            default: ;
         endcase
      endfunction

      // Work out where an accepted request lands and update the shelves.
      function void book_request(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
         int unsigned   need_w;
         int unsigned   need_h;
         int unsigned   pad;
         int unsigned   best;
         int unsigned   n;
         bit            found;
         bit            split;
         placement_type p;
         p.status = STATUS_PLACED;
         p.x      = '0;
         p.y      = '0;
         // whole-map requests go in without a border
         pad    = (w != map_w || h != map_h) ? 1 : 0;
         need_w = w + (pad != 0 ? BORDER_PAD : 0);
         need_h = h + (pad != 0 ? BORDER_PAD : 0);
         // first request ever opens one shelf over the whole map
         if (count == 0) begin
            top[0]    = '0;
            height[0] = map_h;
            used[0]   = '0;
            count     = 1;
         end
         found = 1'b0;
         best  = 0;
         for (int i = 0; i < count; i++) begin
            if (!found || height[i] < height[best]) begin
               if (need_h <= height[i] && used[i] + need_w <= map_w) begin
                  best  = i;
                  found = 1'b1;
               end
            end
         end
         split = found && used[best] == 0 && need_h < height[best];
         if (!found) begin
            p.status = STATUS_NO_FIT;
         end else if (split && count >= MAX_SHELVES) begin
            p.status = STATUS_TBL_FULL;
         end else begin
            if (split) begin
               n         = count;
               top[n]    = POS_W'(top[best] + need_h);
               height[n] = DIM_W'(height[best] - need_h);
               used[n]   = '0;
               count     = n + 1;
               height[best] = DIM_W'(need_h);
            end
            p.x        = POS_W'(used[best] + pad);
            p.y        = POS_W'(top[best] + pad);
            used[best] = DIM_W'(used[best] + need_w);
         end
         placements_due.push_back(p);
      endfunction

      task report(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endtask

      task check_placement(logic [1:0] status, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
         placement_type want;
         if (placements_due.size() == 0) begin
            report($sformatf("result with no request pending: status %0d x %0d y %0d",
                             status, x, y));
            return;
         end
         want = placements_due.pop_front();
         if (status !== want.status || x !== want.x || y !== want.y)
            report($sformatf("status %0d/%0d x %0d/%0d y %0d/%0d (got/expected)",
                             status, want.status, x, want.x, y, want.y));
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [DIM_W-1:0]     req_rect_width;
   logic [DIM_W-1:0]     req_rect_height;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [POS_W-1:0]     rsp_place_x;
   logic [POS_W-1:0]     rsp_place_y;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   shelf_tracker tracker = new();

   // handshake flags, set at the rising edge and read by the drivers at the
   // following falling edge
   logic took_request;
   logic took_write;
   int   quiet_cycles;

   // map size as last written, for building whole-map requests
   logic [DIM_W-1:0] cur_w;
   logic [DIM_W-1:0] cur_h;

   shelf_atlas_allocator DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_place_x     (rsp_place_x),
      .rsp_place_y     (rsp_place_y),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Monitor: everything is sampled at the rising edge. A result strobe and
   // a new request can meet at one edge; the result belongs to the older
   // request, so it is checked before the new one is booked.
   always @(posedge clock) begin
      took_request = 1'b0;
      took_write   = 1'b0;
      if (!reset) begin
         if (rsp_valid === 1'b1)
            tracker.check_placement(rsp_status, rsp_place_x, rsp_place_y);
         if (start && busy === 1'b0) begin
            tracker.book_request(req_rect_width, req_rect_height);
            took_request = 1'b1;
         end
         if (csr_valid && csr_ready === 1'b1) begin
            tracker.set_reg(csr_index, csr_wdata);
            took_write = 1'b1;
         end
      end
      // watchdog: any accepted request, result or register write is progress
      if (took_request || took_write || rsp_valid === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Drivers: entered and left at a falling edge.

   // Hold the request until it is taken; start stays high for a follow-on.
   task automatic send_request(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      start           <= 1'b1;
      req_rect_width  <= w;
      req_rect_height <= h;
      do @(negedge clock); while (!took_request);
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Stop sending and wait until every placement owed has come back.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (tracker.placements_due.size() != 0 || busy !== 1'b0) @(negedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_reg(input csr_index_type idx, input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(negedge clock); while (!took_write);
      csr_valid <= 1'b0;
      if (idx == CSR_MAP_WIDTH)
         cur_w = value;
      else
         cur_h = value;
      @(negedge clock);
   endtask

   task automatic set_map(input int w, input int h);
      write_reg(CSR_MAP_WIDTH, DIM_W'(w));
      write_reg(CSR_MAP_HEIGHT, DIM_W'(h));
   endtask

   initial begin
      int               roll;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      reset           = 1'b1;
      start           = 1'b0;
      req_rect_width  = '0;
      req_rect_height = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_MAP_WIDTH;
      csr_wdata       = '0;
      took_request    = 1'b0;
      took_write      = 1'b0;
      quiet_cycles    = 0;
      cur_w           = MAP_RESET;
      cur_h           = MAP_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---
      // first request fails on width yet still opens the tall covering shelf
      set_map(1, 8191);
      send_request(1, 1);
      drain();
      set_map(4096, 4096);
      send_request(4096, 4096);   // whole map: no border, splits the first shelf; new top wraps past 12 bits
      send_request(0, 0);         // zero size still takes the border
      send_request(4095, 1);      // one column too wide once padded
      send_request(8191, 8191);   // field maxima
      send_request(4094, 5);      // exact width fit
      send_request(1, 0);
      send_request(8191, 1);
      send_request(1, 8191);
      send_request(4096, 4095);   // one short of the whole map, so padded
      send_request(4094, 4094);
      drain();
      set_map(8191, 1);
      send_request(8191, 1);      // whole map, width register at its maximum
      send_request(2, 2);
      send_request(8190, 1);
      drain();

      // --- random phases ---
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_map(PHASE_WIDTH[ph], PHASE_HEIGHT[ph]);
         for (int k = 0; k < PHASE_ITEMS[ph]; k++) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
               // the bulk: small fragments that keep the shelves busy
               w = DIM_W'($urandom_range(1, 48));
               h = DIM_W'($urandom_range(1, 40));
            end else if (roll < 92) begin
               w = DIM_W'($urandom_range(0, 8191));
               h = DIM_W'($urandom_range(0, 8191));
            end else if (roll < 97) begin
               w = cur_w;
               h = cur_h;
            end else begin
               // padded width lands exactly on the map width when that is at least 2
               w = cur_w - DIM_W'(2);
               h = DIM_W'($urandom_range(1, 40));
            end
            if ($urandom_range(99) < 2)
               drain();
            else if ($urandom_range(99) < PHASE_IDLE[ph])
               pause_requests($urandom_range(1, 12));
            send_request(w, h);
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (tracker.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/saa_pkg.sv
rtl/saa_shelf_ram.sv
rtl/shelf_atlas_allocator.sv
test/shelf_atlas_allocator_tb.sv
